// ----- rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: field widths, opcodes, controller
// states and the command/status types between controller and datapath. No dependencies.
package rau_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int OPC_BITS       = 3;
  localparam int WORD_BITS_DEF  = 32;

  typedef enum logic [OPC_BITS-1:0] {
    OP_ADD     = 3'd0,
    OP_MULTIPLY= 3'd1,
    OP_DIVIDE  = 3'd2,
    OP_GREATER = 3'd3,
    OP_EQUAL   = 3'd4,
    OP_REDUCE  = 3'd5,
    OP_NEGATE  = 3'd6,
    OP_INVERT  = 3'd7
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_SUM,
    ST_RED, ST_GCD_CHK, ST_GCD_WAIT, ST_DIVN_GO, ST_DIVN_WAIT,
    ST_DIVD_GO, ST_DIVD_WAIT, ST_RED_END, ST_LOAD_Y, ST_PROD_N,
    ST_PROD_D, ST_DONE
  } state_t;

  // which reduction is running: cross-cancel of the first pair, of the second, or final
  typedef enum logic [1:0] {PH_X, PH_Y, PH_F} phase_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_LD_X, CMD_LD_Y, CMD_LD_A, CMD_LD_NEG, CMD_LD_INV,
    CMD_MUL_AN_BD, CMD_MUL_AD_BN, CMD_MUL_AD_BD, CMD_SUM,
    CMD_MUL_XY_N, CMD_MUL_XY_D, CMD_SAVE_X, CMD_SAVE_Y,
    CMD_RED_ZERO, CMD_RED_PREP, CMD_GCD_GO, CMD_GCD_STEP,
    CMD_DIVN_GO, CMD_DIVN_SAVE, CMD_DIVD_GO, CMD_DIVD_SAVE, CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic num_zero;
    logic y_zero;
    logic div_done;
    op_t  opcode;
  } dp_status_t;

endpackage

// ----- rtl/rau_if.sv -----
// Valid/ready channel interfaces for operation items and result items.
// Depends on rau_pkg.
interface rau_req_if;
  logic                              valid;
  logic                              ready;
  logic [rau_pkg::OPC_BITS-1:0]      opcode;
  logic signed [rau_pkg::FIELD_BITS-1:0] a_num;
  logic signed [rau_pkg::FIELD_BITS-1:0] a_den;
  logic signed [rau_pkg::FIELD_BITS-1:0] b_num;
  logic signed [rau_pkg::FIELD_BITS-1:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [rau_pkg::FIELD_BITS-1:0] result_num;
  logic signed [rau_pkg::FIELD_BITS-1:0] result_den;
  logic                              compare_true;
  logic                              overflow;
  modport source (output valid, result_num, result_den, compare_true, overflow, input ready);
  modport sink (input valid, result_num, result_den, compare_true, overflow, output ready);
endinterface

// ----- rtl/rau_div.sv -----
// Restoring divider, one quotient bit per cycle, for unsigned N-bit operands.
// No package dependency. Divisor must be nonzero.
module rau_div #(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic [N-1:0] remainder
);
  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  q;
  logic [N-1:0]  r;
  logic [N-1:0]  d;
  logic [N:0]    shifted;
  logic [N:0]    diff;

  assign shifted = {r, q[N-1]};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (!diff[N]) begin
        r <= diff[N-1:0];
        q <= {q[N-2:0], 1'b1};
      end else begin
        r <= shifted[N-1:0];
        q <= {q[N-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;
endmodule

// ----- rtl/rau_datapath.sv -----
// Datapath of the rational unit: operand, working-rational and gcd registers,
// one shared multiplier, the divider and the result register. Depends on rau_pkg, rau_div.
module rau_datapath #(
  parameter int W = rau_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rau_pkg::cmd_t                        cmd,
  output rau_pkg::dp_status_t                  status,
  input  logic [rau_pkg::OPC_BITS-1:0]         opcode,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] a_num,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] a_den,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] b_num,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] b_den,
  output logic signed [rau_pkg::FIELD_BITS-1:0] result_num,
  output logic signed [rau_pkg::FIELD_BITS-1:0] result_den,
  output logic                                 compare_true,
  output logic                                 overflow
);
  localparam int N = 2 * W;

  rau_pkg::op_t op;
  // operands, sign-magnitude
  logic an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  // working rational
  logic nneg, dneg;
  logic [N-1:0] nmag, dmag;
  // cross-cancelled halves
  logic xn_neg, xd_neg, yn_neg, yd_neg;
  logic [W-1:0] xn_mag, xd_mag, yn_mag, yd_mag;
  // partial products for add
  logic p_neg, s_neg;
  logic [N-1:0] p_mag, s_mag;
  // Euclid registers
  logic [N-1:0] gx, gy;

  logic [W-1:0] mul_a, mul_b;
  logic         mul_sign;
  logic [N-1:0] prod;
  logic         prod_neg;

  logic         sum_neg;
  logic [N-1:0] sum_mag;

  logic         div_start;
  logic [N-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic         div_done;

  logic         fn_ovf, fd_ovf;
  logic signed [W-1:0] fn_word, fd_word;

  function automatic logic [W:0] to_sm(input logic [rau_pkg::FIELD_BITS-1:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    to_sm = {v[W-1], v[W-1] ? (~v + 1'b1) : v};
  endfunction

  // single shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sign = 1'b0;
    case (cmd)
      rau_pkg::CMD_MUL_AN_BD: begin
        mul_a = an_mag; mul_b = bd_mag; mul_sign = an_neg ^ bd_neg;
      end
      rau_pkg::CMD_MUL_AD_BN: begin
        // greater works on a - b
        mul_a = ad_mag; mul_b = bn_mag;
        mul_sign = ad_neg ^ bn_neg ^ (op == rau_pkg::OP_GREATER);
      end
      rau_pkg::CMD_MUL_AD_BD: begin
        mul_a = ad_mag; mul_b = bd_mag; mul_sign = ad_neg ^ bd_neg;
      end
      rau_pkg::CMD_MUL_XY_N: begin
        mul_a = xn_mag; mul_b = yn_mag; mul_sign = xn_neg ^ yn_neg;
      end
      rau_pkg::CMD_MUL_XY_D: begin
        mul_a = xd_mag; mul_b = yd_mag; mul_sign = xd_neg ^ yd_neg;
      end
      default: ;
    endcase
  end

  assign prod     = N'(mul_a) * N'(mul_b);
  assign prod_neg = mul_sign && (prod != '0);

  // sign-magnitude add of the two partial products
  always_comb begin
    if (p_neg == s_neg) begin
      sum_neg = p_neg;
      sum_mag = p_mag + s_mag;
    end else if (p_mag >= s_mag) begin
      sum_neg = p_neg;
      sum_mag = p_mag - s_mag;
    end else begin
      sum_neg = s_neg;
      sum_mag = s_mag - p_mag;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = gx;
    div_dvs   = gy;
    case (cmd)
      rau_pkg::CMD_GCD_GO: div_start = 1'b1;
      rau_pkg::CMD_DIVN_GO: begin
        div_start = 1'b1; div_dvd = nmag; div_dvs = gx;
      end
      rau_pkg::CMD_DIVD_GO: begin
        div_start = 1'b1; div_dvd = dmag; div_dvs = gx;
      end
      default: ;
    endcase
  end

  rau_div #(.N(N)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // fit to a signed W-bit word, flag when out of range
  always_comb begin
    logic [N-1:0] half;
    logic [N-1:0] vn, vd;
    half    = N'(1) << (W - 1);
    fn_ovf  = nneg ? (nmag > half) : (nmag > half - 1'b1);
    fd_ovf  = dneg ? (dmag > half) : (dmag > half - 1'b1);
    vn      = nneg ? (~nmag + 1'b1) : nmag;
    vd      = dneg ? (~dmag + 1'b1) : dmag;
    fn_word = vn[W-1:0];
    fd_word = vd[W-1:0];
  end

  always_ff @(posedge clk) begin
    logic [W:0] sa, sb, sc, sd;
    sa = to_sm(a_num);
    sb = to_sm(a_den);
    sc = to_sm(b_num);
    sd = to_sm(b_den);
    case (cmd)
      rau_pkg::CMD_LOAD: begin
        op <= rau_pkg::op_t'(opcode);
        {an_neg, an_mag} <= sa;
        {ad_neg, ad_mag} <= sb;
        {bn_neg, bn_mag} <= sc;
        {bd_neg, bd_mag} <= sd;
      end
      rau_pkg::CMD_LD_X: begin
        if (op == rau_pkg::OP_DIVIDE) begin
          nneg <= bd_neg; nmag <= N'(bd_mag);
        end else begin
          nneg <= bn_neg; nmag <= N'(bn_mag);
        end
        dneg <= ad_neg; dmag <= N'(ad_mag);
      end
      rau_pkg::CMD_LD_Y: begin
        nneg <= an_neg; nmag <= N'(an_mag);
        if (op == rau_pkg::OP_DIVIDE) begin
          dneg <= bn_neg; dmag <= N'(bn_mag);
        end else begin
          dneg <= bd_neg; dmag <= N'(bd_mag);
        end
      end
      rau_pkg::CMD_LD_A: begin
        nneg <= an_neg; nmag <= N'(an_mag);
        dneg <= ad_neg; dmag <= N'(ad_mag);
      end
      rau_pkg::CMD_LD_NEG: begin
        nneg <= !an_neg && (an_mag != '0); nmag <= N'(an_mag);
        dneg <= ad_neg; dmag <= N'(ad_mag);
      end
      rau_pkg::CMD_LD_INV: begin
        nneg <= ad_neg; nmag <= N'(ad_mag);
        dneg <= an_neg; dmag <= N'(an_mag);
      end
      rau_pkg::CMD_MUL_AN_BD: begin
        p_neg <= prod_neg; p_mag <= prod;
      end
      rau_pkg::CMD_MUL_AD_BN: begin
        s_neg <= prod_neg; s_mag <= prod;
      end
      rau_pkg::CMD_MUL_AD_BD, rau_pkg::CMD_MUL_XY_D: begin
        dneg <= prod_neg; dmag <= prod;
      end
      rau_pkg::CMD_MUL_XY_N: begin
        nneg <= prod_neg; nmag <= prod;
      end
      rau_pkg::CMD_SUM: begin
        nneg <= sum_neg; nmag <= sum_mag;
      end
      rau_pkg::CMD_SAVE_X: begin
        xn_neg <= nneg; xn_mag <= nmag[W-1:0];
        xd_neg <= dneg; xd_mag <= dmag[W-1:0];
      end
      rau_pkg::CMD_SAVE_Y: begin
        yn_neg <= nneg; yn_mag <= nmag[W-1:0];
        yd_neg <= dneg; yd_mag <= dmag[W-1:0];
      end
      rau_pkg::CMD_RED_ZERO: begin
        nneg <= 1'b0; dneg <= 1'b0; dmag <= N'(1);
      end
      rau_pkg::CMD_RED_PREP: begin
        if (dneg) begin
          dneg <= 1'b0;
          nneg <= !nneg;
        end
        gx <= dmag;
        gy <= nmag;
      end
      rau_pkg::CMD_GCD_STEP: begin
        gx <= gy;
        gy <= div_rem;
      end
      rau_pkg::CMD_DIVN_SAVE: nmag <= div_quo;
      rau_pkg::CMD_DIVD_SAVE: dmag <= div_quo;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd == rau_pkg::CMD_OUT) begin
      if (op == rau_pkg::OP_GREATER || op == rau_pkg::OP_EQUAL) begin
        result_num <= '0;
        result_den <= rau_pkg::FIELD_BITS'(1);
        overflow   <= 1'b0;
        if (op == rau_pkg::OP_GREATER)
          compare_true <= (nmag != '0) && (nneg == dneg);
        else
          compare_true <= ({an_neg, an_mag} == {bn_neg, bn_mag}) &&
                          ({ad_neg, ad_mag} == {bd_neg, bd_mag});
      end else begin
        result_num   <= rau_pkg::FIELD_BITS'(fn_word);
        result_den   <= rau_pkg::FIELD_BITS'(fd_word);
        overflow     <= fn_ovf || fd_ovf;
        compare_true <= 1'b0;
      end
    end
  end

  assign status.num_zero = (nmag == '0);
  assign status.y_zero   = (gy == '0);
  assign status.div_done = div_done;
  assign status.opcode   = op;
endmodule

// ----- rtl/rau_ctrl.sv -----
// Controller of the rational unit: sequences loads, products, Euclid reduction
// and result hand-off through datapath commands. Depends on rau_pkg.
module rau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rau_pkg::dp_status_t status,
  output rau_pkg::cmd_t       cmd
);
  rau_pkg::state_t state, state_next;
  rau_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rau_pkg::ST_IDLE;
      phase     <= rau_pkg::PH_F;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd == rau_pkg::CMD_OUT)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      rau_pkg::ST_IDLE:
        if (in_valid) state_next = rau_pkg::ST_DECODE;
      rau_pkg::ST_DECODE: begin
        unique case (status.opcode)
          rau_pkg::OP_ADD, rau_pkg::OP_GREATER: state_next = rau_pkg::ST_MUL_A;
          rau_pkg::OP_MULTIPLY, rau_pkg::OP_DIVIDE: begin
            phase_next = rau_pkg::PH_X;
            state_next = rau_pkg::ST_RED;
          end
          rau_pkg::OP_REDUCE: begin
            phase_next = rau_pkg::PH_F;
            state_next = rau_pkg::ST_RED;
          end
          default: state_next = rau_pkg::ST_DONE;
        endcase
      end
      rau_pkg::ST_MUL_A: state_next = rau_pkg::ST_MUL_B;
      rau_pkg::ST_MUL_B: state_next = rau_pkg::ST_MUL_C;
      rau_pkg::ST_MUL_C: state_next = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM: begin
        phase_next = rau_pkg::PH_F;
        state_next = (status.opcode == rau_pkg::OP_GREATER) ? rau_pkg::ST_DONE
                                                            : rau_pkg::ST_RED;
      end
      rau_pkg::ST_RED:
        state_next = status.num_zero ? rau_pkg::ST_RED_END : rau_pkg::ST_GCD_CHK;
      rau_pkg::ST_GCD_CHK:
        state_next = status.y_zero ? rau_pkg::ST_DIVN_GO : rau_pkg::ST_GCD_WAIT;
      rau_pkg::ST_GCD_WAIT:
        if (status.div_done) state_next = rau_pkg::ST_GCD_CHK;
      rau_pkg::ST_DIVN_GO: state_next = rau_pkg::ST_DIVN_WAIT;
      rau_pkg::ST_DIVN_WAIT:
        if (status.div_done) state_next = rau_pkg::ST_DIVD_GO;
      rau_pkg::ST_DIVD_GO: state_next = rau_pkg::ST_DIVD_WAIT;
      rau_pkg::ST_DIVD_WAIT:
        if (status.div_done) state_next = rau_pkg::ST_RED_END;
      rau_pkg::ST_RED_END: begin
        unique case (phase)
          rau_pkg::PH_X: state_next = rau_pkg::ST_LOAD_Y;
          rau_pkg::PH_Y: state_next = rau_pkg::ST_PROD_N;
          default:       state_next = rau_pkg::ST_DONE;
        endcase
      end
      rau_pkg::ST_LOAD_Y: begin
        phase_next = rau_pkg::PH_Y;
        state_next = rau_pkg::ST_RED;
      end
      rau_pkg::ST_PROD_N: state_next = rau_pkg::ST_PROD_D;
      rau_pkg::ST_PROD_D: begin
        phase_next = rau_pkg::PH_F;
        state_next = rau_pkg::ST_RED;
      end
      rau_pkg::ST_DONE:
        if (!out_valid || out_ready) state_next = rau_pkg::ST_IDLE;
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = rau_pkg::CMD_NONE;
    in_ready = 1'b0;
    unique case (state)
      rau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = rau_pkg::CMD_LOAD;
      end
      rau_pkg::ST_DECODE: begin
        unique case (status.opcode)
          rau_pkg::OP_MULTIPLY, rau_pkg::OP_DIVIDE: cmd = rau_pkg::CMD_LD_X;
          rau_pkg::OP_REDUCE: cmd = rau_pkg::CMD_LD_A;
          rau_pkg::OP_NEGATE: cmd = rau_pkg::CMD_LD_NEG;
          rau_pkg::OP_INVERT: cmd = rau_pkg::CMD_LD_INV;
          default:            cmd = rau_pkg::CMD_NONE;
        endcase
      end
      rau_pkg::ST_MUL_A: cmd = rau_pkg::CMD_MUL_AN_BD;
      rau_pkg::ST_MUL_B: cmd = rau_pkg::CMD_MUL_AD_BN;
      rau_pkg::ST_MUL_C: cmd = rau_pkg::CMD_MUL_AD_BD;
      rau_pkg::ST_SUM:   cmd = rau_pkg::CMD_SUM;
      rau_pkg::ST_RED:
        cmd = status.num_zero ? rau_pkg::CMD_RED_ZERO : rau_pkg::CMD_RED_PREP;
      rau_pkg::ST_GCD_CHK:
        if (!status.y_zero) cmd = rau_pkg::CMD_GCD_GO;
      rau_pkg::ST_GCD_WAIT:
        if (status.div_done) cmd = rau_pkg::CMD_GCD_STEP;
      rau_pkg::ST_DIVN_GO: cmd = rau_pkg::CMD_DIVN_GO;
      rau_pkg::ST_DIVN_WAIT:
        if (status.div_done) cmd = rau_pkg::CMD_DIVN_SAVE;
      rau_pkg::ST_DIVD_GO: cmd = rau_pkg::CMD_DIVD_GO;
      rau_pkg::ST_DIVD_WAIT:
        if (status.div_done) cmd = rau_pkg::CMD_DIVD_SAVE;
      rau_pkg::ST_RED_END: begin
        unique case (phase)
          rau_pkg::PH_X: cmd = rau_pkg::CMD_SAVE_X;
          rau_pkg::PH_Y: cmd = rau_pkg::CMD_SAVE_Y;
          default:       cmd = rau_pkg::CMD_NONE;
        endcase
      end
      rau_pkg::ST_LOAD_Y: cmd = rau_pkg::CMD_LD_Y;
      rau_pkg::ST_PROD_N: cmd = rau_pkg::CMD_MUL_XY_N;
      rau_pkg::ST_PROD_D: cmd = rau_pkg::CMD_MUL_XY_D;
      rau_pkg::ST_DONE:
        if (!out_valid || out_ready) cmd = rau_pkg::CMD_OUT;
      default: cmd = rau_pkg::CMD_NONE;
    endcase
  end
endmodule

// ----- rtl/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit, top level. Depends on rau_pkg, rau_if, rau_ctrl,
// rau_datapath (which holds rau_div).
//
// One item carries an opcode and two rationals a_num/a_den, b_num/b_den; one
// result item comes back per input item: a numerator, a denominator and two
// flags. Only the low WORD_BITS bits of each operand word are used, read as
// two's complement, and results are WORD_BITS-bit words sign-extended to 32.
// Add, multiply, divide and reduce return a reduced fraction with a
// non-negative denominator (zero numerator gives 0/1); negate and invert are
// not reduced. Greater and equal return 0/1 with compare_true set on a true
// outcome. overflow flags a numerator or denominator that left the signed
// word range; the word is then truncated.
// Timing: one item at a time. Negate, invert and equal pass through accept,
// decode and result before the next ready; greater adds three products and a
// sum. Every reduction of a nonzero numerator runs Euclid's algorithm on a
// shared 2*WORD_BITS-bit restoring divider, one division per step, then two
// more divisions by the gcd; the number of steps is data dependent (up to
// about 90 on 64-bit magnitudes). A zero numerator skips the divider.
// Add does one reduction, multiply and divide three (two cross-cancels and a
// final one). The divider loop sets the rate. The input side is ready again
// as soon as a result is parked in the output register.
module rational_arithmetic_unit_top #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  rau_req_if.sink  req,
  rau_rsp_if.source rsp
);
  rau_pkg::cmd_t       cmd;
  rau_pkg::dp_status_t status;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rau_datapath #(.W(WORD_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (req.opcode),
    .a_num        (req.a_num),
    .a_den        (req.a_den),
    .b_num        (req.b_num),
    .b_den        (req.b_den),
    .result_num   (rsp.result_num),
    .result_den   (rsp.result_den),
    .compare_true (rsp.compare_true),
    .overflow     (rsp.overflow)
  );
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for rational_arithmetic_unit_top: queue-fed driver,
// clocked monitor, and a fraction predictor with scoreboard. Depends on rau_pkg, rau_if, the DUT.
module tb_top;
  import rau_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam logic [63:0] WMASK = (64'd1 << WB) - 64'd1;
  localparam logic [31:0] WMIN = 32'h8000_0000;
  localparam logic [31:0] WMAX = 32'h7fff_ffff;
  localparam int PHASE1_AT = 600;    // items accepted before idling ratios swap
  localparam int PHASE2_AT = 1200;   // items accepted before idling stops
  localparam int HOLD_CYCLES = 20000;
  localparam int N_RANDOM = 1730;

  // signed magnitude with 64-bit magnitude: holds every exact intermediate
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct {
    smag_t num;
    smag_t den;
  } frac_t;

  typedef struct {
    op_t         opcode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } op_item_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        ovf;
  } rat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_req_if req_ch ();
  rau_rsp_if rsp_ch ();

  rational_arithmetic_unit_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  op_item_t    pending_ops[$];
  rat_result_t expected_results[$];
  int          accepted_cnt = 0;
  int          total_ops    = 0;
  int          mismatches   = 0;
  bit          req_fired    = 0;
  int          hold_cnt     = 0;
  bit          hold_done    = 0;

  // ---------------------------------------------------------------------
  // Fraction predictor
  // ---------------------------------------------------------------------
  function automatic smag_t word_to_smag(logic [31:0] w);
    smag_t       s;
    logic [63:0] v;
    v = {32'd0, w} & WMASK;
    if (v[WB-1]) v = v | ~WMASK;
    s.neg = v[63];
    s.mag = s.neg ? (64'd0 - v) : v;
    return s;
  endfunction

  function automatic smag_t smag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (x.neg != y.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    if (x < y) begin
      t = x;
      x = y;
      y = t;
    end
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_t frac_reduce(frac_t r);
    logic [63:0] g;
    if (r.num.mag == 0) begin
      r.num.neg = 0;
      r.den.neg = 0;
      r.den.mag = 64'd1;
      return r;
    end
    if (r.den.neg) begin
      r.den.neg = 0;
      r.num.neg = !r.num.neg;
    end
    g = euclid_gcd(r.den.mag, r.num.mag);
    if (g != 0) begin
      r.num.mag = r.num.mag / g;
      r.den.mag = r.den.mag / g;
    end
    return r;
  endfunction

  function automatic frac_t frac_add(frac_t a, frac_t b);
    frac_t r;
    r.num = smag_add(smag_mul(a.num, b.den), smag_mul(a.den, b.num));
    r.den = smag_mul(a.den, b.den);
    return frac_reduce(r);
  endfunction

  // cross-cancel before the product so the final reduction stays small
  function automatic frac_t frac_mul(frac_t a, frac_t b);
    frac_t x, y, r;
    x.num = b.num;
    x.den = a.den;
    y.num = a.num;
    y.den = b.den;
    x = frac_reduce(x);
    y = frac_reduce(y);
    r.num = smag_mul(x.num, y.num);
    r.den = smag_mul(x.den, y.den);
    return frac_reduce(r);
  endfunction

  function automatic logic [31:0] fit_to_word(smag_t s, inout logic ovf);
    logic [63:0] half, v;
    half = 64'd1 << (WB - 1);
    if (s.neg ? (s.mag > half) : (s.mag > half - 64'd1)) ovf = 1'b1;
    v = s.neg ? (64'd0 - s.mag) : s.mag;
    v = v & WMASK;
    if (v[WB-1]) v = v | ~WMASK;
    return v[31:0];
  endfunction

  function automatic rat_result_t predict_result(op_item_t it);
    frac_t       a, b, r, c;
    rat_result_t res;
    logic        ovf;
    a.num = word_to_smag(it.a_num);
    a.den = word_to_smag(it.a_den);
    b.num = word_to_smag(it.b_num);
    b.den = word_to_smag(it.b_den);
    r = a;
    res = '{num: 32'd0, den: 32'd1, cmp: 1'b0, ovf: 1'b0};
    case (it.opcode)
      OP_ADD:      r = frac_add(a, b);
      OP_MULTIPLY: r = frac_mul(a, b);
      OP_DIVIDE: begin
        c.num = b.den;
        c.den = b.num;
        r = frac_mul(a, c);
      end
      OP_GREATER: begin
        // sign of a - b decides
        b.num.neg = !b.num.neg && (b.num.mag != 0);
        c = frac_add(a, b);
        res.cmp = (c.num.mag != 0) && !c.num.neg;
        return res;
      end
      OP_EQUAL: begin
        res.cmp = ((it.a_num ^ it.b_num) & WMASK[31:0]) == 0 &&
                  ((it.a_den ^ it.b_den) & WMASK[31:0]) == 0;
        return res;
      end
      OP_REDUCE: r = frac_reduce(a);
      OP_NEGATE: r.num.neg = !r.num.neg && (r.num.mag != 0);
      default: begin
        r.num = a.den;
        r.den = a.num;
      end
    endcase
    ovf = 1'b0;
    res.num = fit_to_word(r.num, ovf);
    res.den = fit_to_word(r.den, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'hffff_ffff;
          3: return WMIN;
          default: return WMAX;
        endcase
      end
      3: return $urandom_range(65535) - 32768;
      default: return $urandom_range(200) - 100;  // short Euclid runs
    endcase
  endfunction

  task automatic add_op(op_t opc, logic [31:0] an, logic [31:0] ad,
                        logic [31:0] bn, logic [31:0] bd);
    op_item_t it;
    it = '{opcode: opc, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    pending_ops.push_back(it);
  endtask

  initial begin
    req_ch.valid  = 1'b0;
    req_ch.opcode = '0;
    req_ch.a_num  = '0;
    req_ch.a_den  = '0;
    req_ch.b_num  = '0;
    req_ch.b_den  = '0;
    rsp_ch.ready  = 1'b0;

    // directed: every op, field extremes and the corner cases
    add_op(OP_ADD,      32'd1, 32'd2, 32'd1, 32'd3);
    add_op(OP_ADD,      WMAX, 32'd1, WMAX, 32'd1);                  // overflow
    add_op(OP_ADD,      WMIN, WMIN, WMIN, 32'hffff_ffff);
    add_op(OP_MULTIPLY, 32'd6, 32'd35, 32'd14, 32'd9);
    add_op(OP_MULTIPLY, WMAX, 32'd1, WMAX, 32'd1);
    add_op(OP_MULTIPLY, WMIN, 32'd3, 32'hffff_ffff, 32'd1);
    add_op(OP_DIVIDE,   32'd3, 32'd4, 32'd9, 32'd8);
    add_op(OP_DIVIDE,   32'd5, 32'd7, 32'd0, 32'd3);                // divide by zero
    add_op(OP_GREATER,  32'd1, 32'd2, 32'd1, 32'd3);
    add_op(OP_GREATER,  32'd1, 32'd3, 32'd1, 32'd2);
    add_op(OP_GREATER,  32'd2, 32'd4, 32'd1, 32'd2);                // equal values
    add_op(OP_EQUAL,    32'd2, 32'd4, 32'd2, 32'd4);
    add_op(OP_EQUAL,    32'd2, 32'd4, 32'd1, 32'd2);                // equal value, not literal
    add_op(OP_REDUCE,   32'd12, 32'hffff_fff8, 32'd0, 32'd0);       // negative den
    add_op(OP_REDUCE,   32'd0, 32'd17, 32'd0, 32'd0);               // zero numerator
    add_op(OP_REDUCE,   32'hffff_fff9, 32'd0, 32'd0, 32'd0);        // zero denominator
    add_op(OP_REDUCE,   WMIN, WMIN, WMAX, WMAX);
    add_op(OP_NEGATE,   WMIN, 32'd1, 32'd0, 32'd0);                 // most negative word
    add_op(OP_NEGATE,   32'd5, 32'd10, 32'd0, 32'd0);
    add_op(OP_INVERT,   32'd6, 32'hffff_fffc, 32'd0, 32'd0);
    add_op(OP_INVERT,   32'd0, WMAX, 32'd0, 32'd0);
    add_op(OP_REDUCE,   WMIN, 32'd1, 32'd0, 32'd0);

    // random part
    repeat (N_RANDOM) begin
      add_op(op_t'($urandom_range(7)), rand_operand(), rand_operand(),
             rand_operand(), rand_operand());
    end
    total_ops = pending_ops.size();

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    wait (accepted_cnt == total_ops && expected_results.size() == 0);
    repeat (300) @(posedge clk);  // catch stray result items
    if (mismatches == 0) begin
      $display("rational_arithmetic_unit_top regression: pass");
    end else begin
      $display("rational_arithmetic_unit_top regression: fail");
    end
    $finish;
  end

  // worst case: three full reductions per item plus stalls, several times over
  initial begin
    #(64'd12 * 64'd1750 * 64'd40000);
    $display("rational_arithmetic_unit_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: new item at the falling edge once the previous one was taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    int       send_idle;
    bit       draining;
    op_item_t it;
    send_idle = (accepted_cnt < PHASE1_AT) ? 24 : (accepted_cnt < PHASE2_AT) ? 65 : 0;
    // one pause at the phase change until every result is back
    draining = (accepted_cnt == PHASE1_AT) && (expected_results.size() != 0);
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (pending_ops.size() != 0 && !draining && $urandom_range(99) >= send_idle) begin
        it = pending_ops.pop_front();
        req_ch.opcode <= it.opcode;
        req_ch.a_num  <= it.a_num;
        req_ch.a_den  <= it.a_den;
        req_ch.b_num  <= it.b_num;
        req_ch.b_den  <= it.b_den;
        req_ch.valid  <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    int recv_idle;
    recv_idle = (accepted_cnt < PHASE1_AT) ? 65 : (accepted_cnt < PHASE2_AT) ? 24 : 0;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= PHASE2_AT) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and scoreboard, sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    op_item_t    it;
    rat_result_t want;
    req_fired = 0;
    if (!rst && req_ch.valid && req_ch.ready) begin
      it = '{opcode: op_t'(req_ch.opcode), a_num: req_ch.a_num, a_den: req_ch.a_den,
             b_num: req_ch.b_num, b_den: req_ch.b_den};
      expected_results.push_back(predict_result(it));
      accepted_cnt++;
      req_fired = 1;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.result_num !== want.num) begin
          $error("result_num: expected %h, got %h", want.num, rsp_ch.result_num);
          mismatches++;
        end
        if (rsp_ch.result_den !== want.den) begin
          $error("result_den: expected %h, got %h", want.den, rsp_ch.result_den);
          mismatches++;
        end
        if (rsp_ch.compare_true !== want.cmp) begin
          $error("compare_true: expected %b, got %b", want.cmp, rsp_ch.compare_true);
          mismatches++;
        end
        if (rsp_ch.overflow !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, rsp_ch.overflow);
          mismatches++;
        end
      end
    end
  end

endmodule

// ----- rational_arithmetic_unit_top.f -----
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_div.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit_top.sv
sim/tb_top.sv
